// ===== hdl/block_index_key_lookup_defines.svh =====
// Assertion macros for the block index key lookup.
`ifndef BLOCK_INDEX_KEY_LOOKUP_DEFINES_SVH
`define BLOCK_INDEX_KEY_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIKL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bikl check failed");

// Next-cycle implication, checked outside reset.
`define BIKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bikl check failed");

`endif

// ===== hdl/bikl_pkg.sv =====
// Constants, codes and state type for the block index key lookup.
package bikl_pkg;

    localparam int MAX_ENTRIES_DEF       = 4096;
    localparam int ENTRIES_PER_BLOCK_DEF = 32;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] STS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STS_MISS  = 2'd1;
    localparam logic [ST_W-1:0] STS_FULL  = 2'd2;
    localparam logic [ST_W-1:0] STS_ORDER = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SRCH_RD  = 4'b0010,
        S_SRCH_CMP = 4'b0100,
        S_SCAN     = 4'b1000
    } t_state;

endpackage

// ===== hdl/bikl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bikl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/block_index_key_lookup.sv =====
// Top level of the block index key lookup: sequencer, shared comparator and stores.
//
//  channel   handshake           fields
//  -------   -----------------   -------------------------------------
//  command   start / busy        i_operation, i_key, i_value
//  result    o_strobe (1 cycle)  o_status, o_found_value
//
// Clear, load and unused codes: result one cycle after acceptance, busy stays low.
// Lookup: a read state and a compare state per binary-search step over the block
// maxima (up to floor(log2(blocks)) + 1 steps, 8 at default size), a decision state,
// then one key read per cycle over the block behind the registered read data, and a
// closing step on a miss; the result comes in the first cycle busy is low. The memory
// read port and the single 64-bit comparator set this pace.
// Synchronous active-low reset empties the table; stores are not swept.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "block_index_key_lookup_defines.svh"

module block_index_key_lookup #(
    parameter int MAX_ENTRIES       = bikl_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRIES_PER_BLOCK = bikl_pkg::ENTRIES_PER_BLOCK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bikl_pkg::OP_W-1:0]     i_operation,
    input  logic [bikl_pkg::KEY_W-1:0]    i_key,
    input  logic [bikl_pkg::VAL_W-1:0]    i_value,
    output logic                          o_strobe,
    output logic [bikl_pkg::ST_W-1:0]     o_status,
    output logic [bikl_pkg::VAL_W-1:0]    o_found_value
);

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int BLOCKS = (MAX_ENTRIES + ENTRIES_PER_BLOCK - 1) / ENTRIES_PER_BLOCK;
    localparam int BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int BCW    = $clog2(BLOCKS + 1);
    localparam int SW     = $clog2(ENTRIES_PER_BLOCK);
    localparam int PW     = CW + 9;

    bikl_pkg::t_state r_state, n_state;

    logic [CW-1:0]                 r_count, n_count;
    logic [SW-1:0]                 r_slot, n_slot;
    logic [BCW-1:0]                r_wblk, n_wblk;
    logic [bikl_pkg::KEY_W-1:0]    r_last_key, n_last_key;
    logic [bikl_pkg::KEY_W-1:0]    r_key, n_key;
    logic [BCW-1:0]                r_lo, n_lo;
    logic [BCW-1:0]                r_hi, n_hi;
    logic [CW-1:0]                 r_addr, n_addr;
    logic [CW-1:0]                 r_last, n_last;
    logic                          r_pend, n_pend;
    logic                          r_strobe, n_strobe;
    logic [bikl_pkg::ST_W-1:0]     r_status, n_status;
    logic [bikl_pkg::VAL_W-1:0]    r_value, n_value;

    logic                          accept;
    logic                          we;
    logic [BCW-1:0]                blocks_used;
    logic [BCW-1:0]                mid;
    logic [PW-1:0]                 first_full;
    logic [PW-1:0]                 end_full;
    logic [CW-1:0]                 scan_end;
    logic                          issue;
    logic [bikl_pkg::KEY_W-1:0]    key_rdata;
    logic [bikl_pkg::VAL_W-1:0]    val_rdata;
    logic [bikl_pkg::KEY_W-1:0]    bm_rdata;
    logic [bikl_pkg::KEY_W-1:0]    cmp_a;
    logic                          cmp_lt;
    logic                          cmp_eq;

    assign accept      = start && !busy;
    assign busy        = (r_state != bikl_pkg::S_IDLE);
    assign blocks_used = r_wblk + BCW'(r_slot != '0);
    assign mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign first_full  = PW'(r_lo) * PW'(ENTRIES_PER_BLOCK);
    assign end_full    = first_full + PW'(ENTRIES_PER_BLOCK);
    assign scan_end    = (end_full > PW'(r_count)) ? r_count : end_full[CW-1:0];
    assign issue       = (r_addr < r_last);

    // One comparator, shared by the block search and the entry scan.
    assign cmp_a  = (r_state == bikl_pkg::S_SRCH_CMP) ? bm_rdata : key_rdata;
    assign cmp_lt = (cmp_a < r_key);
    assign cmp_eq = (cmp_a == r_key);

    bikl_ram #(.WIDTH(bikl_pkg::KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_key),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (key_rdata)
    );

    bikl_ram #(.WIDTH(bikl_pkg::VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (val_rdata)
    );

    bikl_ram #(.WIDTH(bikl_pkg::KEY_W), .DEPTH(BLOCKS)) u_bmax_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wblk[BW-1:0]),
        .i_wdata (i_key),
        .i_raddr (mid[BW-1:0]),
        .o_rdata (bm_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_slot     = r_slot;
        n_wblk     = r_wblk;
        n_last_key = r_last_key;
        n_key      = r_key;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_addr     = r_addr;
        n_last     = r_last;
        n_pend     = r_pend;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_value    = r_value;
        we         = 1'b0;

        case (r_state)
            bikl_pkg::S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_status = bikl_pkg::STS_OK;
                    n_value  = '0;
                    case (i_operation)
                        bikl_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_slot  = '0;
                            n_wblk  = '0;
                        end
                        bikl_pkg::OP_LOAD: begin
                            if (r_count == CW'(MAX_ENTRIES)) begin
                                n_status = bikl_pkg::STS_FULL;
                            end else if (r_count != '0 && i_key <= r_last_key) begin
                                n_status = bikl_pkg::STS_ORDER;
                            end else begin
                                we         = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_last_key = i_key;
                                if (r_slot == SW'(ENTRIES_PER_BLOCK - 1)) begin
                                    n_slot = '0;
                                    n_wblk = r_wblk + 1'b1;
                                end else begin
                                    n_slot = r_slot + 1'b1;
                                end
                            end
                        end
                        bikl_pkg::OP_LOOKUP: begin
                            n_strobe = 1'b0;
                            n_key    = i_key;
                            n_lo     = '0;
                            n_hi     = blocks_used;
                            n_state  = bikl_pkg::S_SRCH_RD;
                        end
                        default: begin
                            n_status = bikl_pkg::STS_OK;
                        end
                    endcase
                end
            end
            bikl_pkg::S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_state = bikl_pkg::S_SRCH_CMP;
                end else if (r_lo >= blocks_used) begin
                    n_strobe = 1'b1;
                    n_status = bikl_pkg::STS_MISS;
                    n_value  = '0;
                    n_state  = bikl_pkg::S_IDLE;
                end else begin
                    n_addr  = first_full[CW-1:0];
                    n_last  = scan_end;
                    n_pend  = 1'b0;
                    n_state = bikl_pkg::S_SCAN;
                end
            end
            bikl_pkg::S_SRCH_CMP: begin
                if (cmp_lt) begin
                    n_lo = mid + 1'b1;
                end else begin
                    n_hi = mid;
                end
                n_state = bikl_pkg::S_SRCH_RD;
            end
            bikl_pkg::S_SCAN: begin
                // Issue the next read while comparing the one issued last cycle.
                n_pend = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_pend && cmp_eq) begin
                    n_strobe = 1'b1;
                    n_status = bikl_pkg::STS_OK;
                    n_value  = val_rdata;
                    n_state  = bikl_pkg::S_IDLE;
                end else if (!issue && !r_pend) begin
                    n_strobe = 1'b1;
                    n_status = bikl_pkg::STS_MISS;
                    n_value  = '0;
                    n_state  = bikl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bikl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bikl_pkg::S_IDLE;
            r_count  <= '0;
            r_slot   <= '0;
            r_wblk   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_slot   <= n_slot;
            r_wblk   <= n_wblk;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_key <= n_last_key;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_addr     <= n_addr;
        r_last     <= n_last;
        r_status   <= n_status;
        r_value    <= n_value;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_value = r_value;

    `BIKL_ASSERT_NEXT(a_lookup_goes_busy, i_clk, i_rst_n,
        accept && i_operation == bikl_pkg::OP_LOOKUP, busy && !o_strobe)
    `BIKL_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n,
        1'b1, r_count <= CW'(MAX_ENTRIES))
    `BIKL_ASSERT_NOW(a_full_only_when_full, i_clk, i_rst_n,
        o_strobe && o_status == bikl_pkg::STS_FULL, r_count == CW'(MAX_ENTRIES))
    `BIKL_ASSERT_NOW(a_lookup_end_reports, i_clk, i_rst_n,
        $fell(busy), o_strobe)

endmodule

// ===== sim/bikl_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for the block index key lookup: follows both channels, predicts and compares.
module bikl_checker #(
    parameter int TABLE_DEPTH = bikl_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_LEN   = bikl_pkg::ENTRIES_PER_BLOCK_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [bikl_pkg::OP_W-1:0]  i_operation,
    input  logic [bikl_pkg::KEY_W-1:0] i_key,
    input  logic [bikl_pkg::VAL_W-1:0] i_value,
    input  logic                       i_strobe,
    input  logic [bikl_pkg::ST_W-1:0]  i_status,
    input  logic [bikl_pkg::VAL_W-1:0] i_found_value,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int BLOCK_TOTAL = (TABLE_DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;

    typedef struct packed {
        logic [bikl_pkg::ST_W-1:0]  status;
        logic [bikl_pkg::VAL_W-1:0] value;
    } t_reply;

    logic [bikl_pkg::KEY_W-1:0] stored_key [TABLE_DEPTH];
    logic [bikl_pkg::VAL_W-1:0] stored_val [TABLE_DEPTH];
    logic [bikl_pkg::KEY_W-1:0] block_top  [BLOCK_TOTAL];
    int unsigned                fill = 0;
    t_reply                     replies_due [$];
    int                         mismatches = 0;

    assign o_fail_count = mismatches;

    initial o_pending = 0;

    function automatic t_reply predict_table_reply(input logic [bikl_pkg::OP_W-1:0]  op,
                                                   input logic [bikl_pkg::KEY_W-1:0] key,
                                                   input logic [bikl_pkg::VAL_W-1:0] val);
        t_reply      reply;
        int unsigned blocks;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned first;
        int unsigned last;
        int unsigned idx;
        reply.status = bikl_pkg::STS_OK;
        reply.value  = '0;
        case (op)
            bikl_pkg::OP_CLEAR: begin
                // entries stay in the stores but drop out of reach
                fill = 0;
            end
            bikl_pkg::OP_LOAD: begin
                if (fill >= TABLE_DEPTH) begin
                    reply.status = bikl_pkg::STS_FULL;
                end else if (fill > 0 && key <= stored_key[fill-1]) begin
                    reply.status = bikl_pkg::STS_ORDER;
                end else begin
                    stored_key[fill]           = key;
                    stored_val[fill]           = val;
                    block_top[fill/BLOCK_LEN]  = key;
                    fill                       = fill + 1;
                end
            end
            bikl_pkg::OP_LOOKUP: begin
                blocks = (fill + BLOCK_LEN - 1) / BLOCK_LEN;
                lo     = 0;
                hi     = blocks;
                // first block whose top key is not below the search key
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (block_top[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                reply.status = bikl_pkg::STS_MISS;
                if (lo < blocks) begin
                    first = lo * BLOCK_LEN;
                    last  = first + BLOCK_LEN;
                    if (last > fill) begin
                        last = fill;
                    end
                    for (idx = first; idx < last; idx++) begin
                        if (stored_key[idx] == key) begin
                            reply.status = bikl_pkg::STS_OK;
                            reply.value  = stored_val[idx];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_reply due;
        if (!i_rst_n) begin
            replies_due.delete();
            fill = 0;
        end else begin
            // retire the reply first: it always belongs to an earlier item
            if (i_strobe) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply with none due, expected none, actual status %0d value %h",
                             $time, i_status, i_found_value);
                    mismatches++;
                end else begin
                    due = replies_due.pop_front();
                    if (i_status !== due.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, due.status, i_status);
                        mismatches++;
                    end
                    if (i_found_value !== due.value) begin
                        $display("%0t: found_value mismatch, expected %h, actual %h",
                                 $time, due.value, i_found_value);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                replies_due.push_back(predict_table_reply(i_operation, i_key, i_value));
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

// ===== sim/tb_block_index_key_lookup.sv =====
`timescale 1ns / 100ps
// Testbench top for the block index key lookup: clock, reset, stimulus and verdict.
module tb_block_index_key_lookup;

    localparam logic [bikl_pkg::OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam int                         TABLE_DEPTH  = bikl_pkg::MAX_ENTRIES_DEF;
    localparam int                         BLOCK_LEN    = bikl_pkg::ENTRIES_PER_BLOCK_DEF;
    localparam logic [bikl_pkg::KEY_W-1:0] KEY_TOP      = '1;
    localparam int                         RANDOM_ITEMS = 550;
    localparam int                         TAIL_CYCLES  = 64;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [bikl_pkg::OP_W-1:0]  i_operation;
    logic [bikl_pkg::KEY_W-1:0] i_key;
    logic [bikl_pkg::VAL_W-1:0] i_value;
    logic                       o_strobe;
    logic [bikl_pkg::ST_W-1:0]  o_status;
    logic [bikl_pkg::VAL_W-1:0] o_found_value;
    int                         fail_count;
    int                         pending;
    logic [bikl_pkg::KEY_W-1:0] held_keys [$];   // keys the table holds, in load order
    int                         counted_items;
    bit                         no_gaps;

    always #5 i_clk = ~i_clk;

    block_index_key_lookup DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found_value (o_found_value)
    );

    bikl_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_found_value (o_found_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Hold start high until the item is taken; start stays up for a back-to-back item.
    task automatic send_item(input logic [bikl_pkg::OP_W-1:0]  op,
                             input logic [bikl_pkg::KEY_W-1:0] key,
                             input logic [bikl_pkg::VAL_W-1:0] val);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0 && !no_gaps) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        if (op != OP_UNUSED) begin
            counted_items++;
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic clear_table();
        send_item(bikl_pkg::OP_CLEAR, rand64(), rand64());
        held_keys.delete();
    endtask

    task automatic load_key(input logic [bikl_pkg::KEY_W-1:0] key,
                            input logic [bikl_pkg::VAL_W-1:0] val);
        send_item(bikl_pkg::OP_LOAD, key, val);
        if (held_keys.size() < TABLE_DEPTH && (held_keys.size() == 0 || key > held_keys[$])) begin
            held_keys.push_back(key);
        end
    endtask

    // Ascending keys spread over the room left above the last key; dense runs keep gaps tiny.
    task automatic load_run(input int count, input bit dense);
        logic [bikl_pkg::KEY_W-1:0] low;
        logic [bikl_pkg::KEY_W-1:0] span;
        logic [bikl_pkg::KEY_W-1:0] key;
        logic [bikl_pkg::VAL_W-1:0] val;
        int                         left;
        for (left = count; left > 0; left--) begin
            if (held_keys.size() == 0) begin
                low = '0;
            end else if (held_keys[$] == KEY_TOP) begin
                low = KEY_TOP;
            end else begin
                low = held_keys[$] + 1;
            end
            span = (KEY_TOP - low) / left;
            if (dense && span > 3) begin
                span = 3;
            end
            key = (span == 0) ? low : low + (rand64() % span);
            val = ($urandom_range(0, 9) == 0) ? '0 : rand64();
            load_key(key, val);
        end
    endtask

    task automatic load_out_of_order();
        logic [bikl_pkg::KEY_W-1:0] last;
        logic [bikl_pkg::KEY_W-1:0] key;
        if (held_keys.size() == 0) begin
            load_run(1, 1'b0);
        end else begin
            last = held_keys[$];
            if ($urandom_range(0, 2) == 0 || last == KEY_TOP) begin
                key = last;
            end else begin
                key = rand64() % (last + 1);
            end
            load_key(key, rand64());
        end
    endtask

    task automatic lookup_some();
        logic [bikl_pkg::KEY_W-1:0] key;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (held_keys.size() == 0 || pick < 15) begin
            key = rand64();
        end else if (pick < 60) begin
            key = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end else if (pick < 80) begin
            key = held_keys[$urandom_range(0, held_keys.size() - 1)];
            key = $urandom_range(0, 1) ? key + 1 : key - 1;
        end else if (pick < 88) begin
            key = held_keys[$] + $urandom_range(0, 1);
        end else if (pick < 94) begin
            key = held_keys[0] - $urandom_range(0, 1);
        end else begin
            key = $urandom_range(0, 1) ? KEY_TOP : '0;
        end
        send_item(bikl_pkg::OP_LOOKUP, key, rand64());
    endtask

    initial begin
        int choice;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= bikl_pkg::OP_CLEAR;
        i_key       <= '0;
        i_value     <= '0;
        no_gaps      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, order errors, zero values, clear
        send_item(bikl_pkg::OP_LOOKUP, '0, '0);
        send_item(bikl_pkg::OP_LOOKUP, KEY_TOP, KEY_TOP);
        send_item(OP_UNUSED, KEY_TOP, KEY_TOP);
        load_key('0, KEY_TOP);
        load_key('0, 64'h1);
        send_item(bikl_pkg::OP_LOOKUP, '0, '0);
        load_key(64'd5, '0);
        send_item(bikl_pkg::OP_LOOKUP, 64'd5, KEY_TOP);
        send_item(bikl_pkg::OP_LOOKUP, 64'd3, '0);
        send_item(bikl_pkg::OP_LOOKUP, 64'd6, '0);
        load_key(64'd4, KEY_TOP);
        load_key(KEY_TOP, 64'hA5A5_5A5A_F00F_0FF0);
        send_item(bikl_pkg::OP_LOOKUP, KEY_TOP, '0);
        load_key(KEY_TOP, 64'h1);
        send_item(bikl_pkg::OP_LOOKUP, KEY_TOP - 1, '0);
        clear_table();
        send_item(bikl_pkg::OP_LOOKUP, KEY_TOP, '0);
        load_key(64'd7, 64'd1);
        send_item(bikl_pkg::OP_LOOKUP, 64'd7, '0);
        clear_table();
        wait_drained();

        // fill the table to the brim, then probe full status and block edges
        no_gaps = 1'b1;
        load_run(TABLE_DEPTH, 1'b0);
        no_gaps = 1'b0;
        load_key(KEY_TOP, rand64());
        load_key('0, rand64());
        send_item(bikl_pkg::OP_LOOKUP, held_keys[0], '0);
        send_item(bikl_pkg::OP_LOOKUP, held_keys[BLOCK_LEN-1], '0);
        send_item(bikl_pkg::OP_LOOKUP, held_keys[BLOCK_LEN], '0);
        send_item(bikl_pkg::OP_LOOKUP, held_keys[BLOCK_LEN] - 1, '0);
        send_item(bikl_pkg::OP_LOOKUP, held_keys[$], '0);
        send_item(bikl_pkg::OP_LOOKUP, held_keys[$] + 1, '0);
        repeat (10) lookup_some();
        wait_drained();
        clear_table();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            choice  = $urandom_range(0, 99);
            if (choice < 6) begin
                clear_table();
            end else if (choice < 38) begin
                load_run(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12),
                         $urandom_range(0, 2) == 0);
            end else if (choice < 86) begin
                repeat ($urandom_range(1, 8)) lookup_some();
            end else if (choice < 94) begin
                load_out_of_order();
            end else begin
                send_item(OP_UNUSED, rand64(), rand64());
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bikl_pkg.sv
hdl/bikl_ram.sv
hdl/block_index_key_lookup.sv
sim/bikl_checker.sv
sim/tb_block_index_key_lookup.sv
